/* src/rms_vu_level_envelope_top_macros.svh */
// Assertion macros used by the checker of the level meter.
`ifndef RMS_VU_LEVEL_ENVELOPE_TOP_MACROS_SVH
`define RMS_VU_LEVEL_ENVELOPE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RMSVU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RMSVU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rmsvu_pkg.sv */
package rmsvu_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ENV_W      = 16;
	localparam int GAIN_W     = 12;
	localparam int CFG_W      = 16;
	localparam int COL_W      = 8;
	localparam int LUT_SIZE   = 256;
	localparam int MAX_BUFFER = 4096;

	localparam int CNT_W   = $clog2(MAX_BUFFER + 1);
	// A square of a signed sample is at most 2^(2*SAMPLE_W-2).
	localparam int SQ_W    = 2 * SAMPLE_W - 1;
	localparam int SUM_W   = SQ_W + $clog2(MAX_BUFFER);
	localparam int ROOT_W  = SAMPLE_W;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int QUO_W   = (SUM_W > RAD_W) ? SUM_W : RAD_W;
	localparam int LPROD_W = ROOT_W + GAIN_W;
	localparam int LVL_SHIFT = 7;
	localparam int LUT_W   = $clog2(LUT_SIZE);
	localparam int STEP_W  = $clog2(QUO_W);

	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BUFFER);
	localparam logic [ENV_W-1:0]  ENV_MAX   = {ENV_W{1'b1}};
	localparam logic [LUT_W-1:0]  LUT_MAX   = LUT_W'(LUT_SIZE - 1);

	localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(768);
	localparam logic [ENV_W-1:0]  ATTACK_RST = ENV_W'(58982);
	localparam logic [ENV_W-1:0]  DECAY_RST  = ENV_W'(3277);

	typedef enum logic [1:0] {
		CFG_GAIN         = 2'd0,
		CFG_ATTACK_COEFF = 2'd1,
		CFG_DECAY_COEFF  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic acc;
		logic div_step;
		logic sqrt_step;
		logic mul;
		logic lvl;
		logic emul;
		logic upd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
	} stat_t;

endpackage

/* src/rmsvu_ctrl.sv */
module rmsvu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output rmsvu_pkg::cmd_t      cmd,
	input  rmsvu_pkg::stat_t     stat
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ACC  = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_SQRT = 9'b000001000,
		ST_MUL  = 9'b000010000,
		ST_LVL  = 9'b000100000,
		ST_EMUL = 9'b001000000,
		ST_UPD  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t                        state_q, state_d;
	logic [rmsvu_pkg::STEP_W-1:0]  step_q, step_d;
	logic                          out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				step_d  = '0;
				state_d = stat.last ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == rmsvu_pkg::DIV_LAST) begin
					step_d  = '0;
					state_d = ST_SQRT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == rmsvu_pkg::SQRT_LAST) begin
					step_d  = '0;
					state_d = ST_MUL;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LVL;
			end
			ST_LVL: begin
				cmd.lvl = 1'b1;
				state_d = ST_EMUL;
			end
			ST_EMUL: begin
				cmd.emul = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// The output register must be free or emptying this cycle.
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/rmsvu_dp.sv */
module rmsvu_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rmsvu_pkg::cmd_t                  cmd,
	output rmsvu_pkg::stat_t                 stat,
	input  logic [rmsvu_pkg::SAMPLE_W-1:0]   sample,
	input  logic                             last,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [rmsvu_pkg::CFG_W-1:0]      cfg_data,
	output logic [rmsvu_pkg::ENV_W-1:0]      envelope_level,
	output logic [rmsvu_pkg::COL_W-1:0]      colour_index
);

	localparam int ENV_W  = rmsvu_pkg::ENV_W;
	localparam int ROOT_W = rmsvu_pkg::ROOT_W;
	localparam int CNT_W  = rmsvu_pkg::CNT_W;
	localparam int QUO_W  = rmsvu_pkg::QUO_W;
	localparam int SUM_W  = rmsvu_pkg::SUM_W;

	// Configuration registers.
	logic [rmsvu_pkg::GAIN_W-1:0] gain_q;
	logic [ENV_W-1:0]             attack_q;
	logic [ENV_W-1:0]             decay_q;

	// Accumulation.
	logic [rmsvu_pkg::SQ_W-1:0]   sq_s1;
	logic                         last_q;
	logic [SUM_W-1:0]             sum_q, sum_nxt;
	logic [CNT_W-1:0]             cnt_q, cnt_nxt;
	logic signed [2*rmsvu_pkg::SAMPLE_W-1:0] sq_full;

	// Shared quotient / radicand shift register, divider and root remainders.
	logic [QUO_W-1:0]             quo_q;
	logic [CNT_W-1:0]             rem_q;
	logic [ROOT_W:0]              sr_q;
	logic [ROOT_W-1:0]            root_q;
	logic                         zcnt_q;

	logic [CNT_W:0]               div_trial;
	logic                         div_ge;
	logic [ROOT_W+2:0]            sq_part;
	logic [ROOT_W+2:0]            sq_trial;
	logic                         sq_ge;

	// Level and envelope.
	logic [rmsvu_pkg::LPROD_W-1:0] lprod_q;
	logic [rmsvu_pkg::LPROD_W-1:0] lshift;
	logic [ROOT_W-1:0]             rms;
	logic [ENV_W-1:0]              level_q;
	logic [ENV_W-1:0]              env_q;
	logic [ENV_W-1:0]              alpha;
	logic signed [ENV_W:0]         diff;
	logic signed [2*ENV_W+1:0]     eprod_q;
	logic signed [ENV_W+1:0]       step;
	logic signed [ENV_W+2:0]       env_new;
	logic [ENV_W+rmsvu_pkg::LUT_W-1:0] col_prod;

	logic [ENV_W-1:0]             out_env_q;
	logic [rmsvu_pkg::COL_W-1:0]  out_col_q;

	assign stat.last = last_q;

	assign sq_full = $signed(sample) * $signed(sample);

	always_comb begin
		if (cnt_q < rmsvu_pkg::CNT_MAX) begin
			sum_nxt = sum_q + SUM_W'(sq_s1);
			cnt_nxt = cnt_q + 1'b1;
		end else begin
			sum_nxt = sum_q;
			cnt_nxt = cnt_q;
		end
	end

	// One restoring division step: quotient bits shift in at the bottom.
	assign div_trial = {rem_q, quo_q[QUO_W-1]};
	assign div_ge    = (div_trial >= {1'b0, cnt_q});

	// One digit of the square root: two radicand bits at a time.
	assign sq_part  = {sr_q, quo_q[rmsvu_pkg::RAD_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = (sq_part >= sq_trial);

	assign rms    = zcnt_q ? '0 : root_q;
	assign lshift = lprod_q >> rmsvu_pkg::LVL_SHIFT;

	assign alpha = (level_q > env_q) ? attack_q : decay_q;
	assign diff  = $signed({1'b0, level_q}) - $signed({1'b0, env_q});

	// Arithmetic shift gives the floor also for a negative product.
	assign step    = $signed(eprod_q[2*ENV_W+1:ENV_W]);
	assign env_new = $signed({3'b000, env_q}) + $signed({step[ENV_W+1], step});

	assign col_prod = env_q * rmsvu_pkg::LUT_MAX;

	assign envelope_level = out_env_q;
	assign colour_index   = out_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= rmsvu_pkg::GAIN_RST;
			attack_q <= rmsvu_pkg::ATTACK_RST;
			decay_q  <= rmsvu_pkg::DECAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmsvu_pkg::CFG_GAIN:         gain_q   <= cfg_data[rmsvu_pkg::GAIN_W-1:0];
				rmsvu_pkg::CFG_ATTACK_COEFF: attack_q <= cfg_data[ENV_W-1:0];
				rmsvu_pkg::CFG_DECAY_COEFF:  decay_q  <= cfg_data[ENV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			env_q <= '0;
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_nxt;
				cnt_q <= cnt_nxt;
			end else if (cmd.load_out) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.upd) begin
				if (env_new < 0) begin
					env_q <= '0;
				end else if (env_new > $signed({3'b000, rmsvu_pkg::ENV_MAX})) begin
					env_q <= rmsvu_pkg::ENV_MAX;
				end else begin
					env_q <= env_new[ENV_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sq_s1  <= sq_full[rmsvu_pkg::SQ_W-1:0];
			last_q <= last;
		end
		if (cmd.acc) begin
			quo_q  <= QUO_W'(sum_nxt);
			rem_q  <= '0;
			sr_q   <= '0;
			root_q <= '0;
			zcnt_q <= (cnt_nxt == '0);
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? CNT_W'(div_trial - {1'b0, cnt_q}) : CNT_W'(div_trial);
			quo_q <= {quo_q[QUO_W-2:0], div_ge};
		end
		if (cmd.sqrt_step) begin
			sr_q   <= sq_ge ? (ROOT_W+1)'(sq_part - sq_trial) : (ROOT_W+1)'(sq_part);
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
			quo_q  <= quo_q << 2;
		end
		if (cmd.mul) begin
			lprod_q <= rms * gain_q;
		end
		if (cmd.lvl) begin
			if (lshift > rmsvu_pkg::LPROD_W'(rmsvu_pkg::ENV_MAX)) begin
				level_q <= rmsvu_pkg::ENV_MAX;
			end else begin
				level_q <= lshift[ENV_W-1:0];
			end
		end
		if (cmd.emul) begin
			eprod_q <= $signed({1'b0, alpha}) * diff;
		end
		if (cmd.load_out) begin
			out_env_q <= env_q;
			out_col_q <= rmsvu_pkg::COL_W'(col_prod >> ENV_W);
		end
	end

endmodule

/* src/rms_vu_level_envelope_top.sv */
// A closing sample shows its result on m_tvalid after the divide, root, gain and smoothing steps.
// No new sample is taken until the previous one is through, and a closing sample holds the input
// off through the one-bit-per-cycle divider over the 43-bit sum and the 16-step square root.
// A finished result waits in the output register while the next buffer is accumulated.
// Reset (arst_n low, asynchronous): sum, count and envelope clear to zero, the
// registers return to gain 6.0, attack 0.9 and decay 0.05, and no result is pending.
module rms_vu_level_envelope_top (
	input  logic        clk,
	input  logic        arst_n,
	// Sample stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample (signed)
	input  logic        s_tlast,   // last sample of a buffer
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] envelope_level, [23:16] colour_index
	// Register writes: 0 gain, 1 attack_coeff, 2 decay_coeff.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// The controller takes each sample through accumulate, and a closing one on through divide,
	// square root, gain, smoothing and output load. The datapath holds all the
	// arithmetic and the configuration registers, and reports only whether the
	// accepted sample closed its buffer.
	rmsvu_pkg::cmd_t                   cmd;
	rmsvu_pkg::stat_t                  stat;
	logic [rmsvu_pkg::ENV_W-1:0]       envelope_level;
	logic [rmsvu_pkg::COL_W-1:0]       colour_index;

	rmsvu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The square of each sample is registered on acceptance and added to the
	// running sum in the following cycle. Samples past the buffer limit are
	// dropped, but a closing mark on one of them still ends the buffer.
	rmsvu_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.sample         (s_tdata),
		.last           (s_tlast),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.envelope_level (envelope_level),
		.colour_index   (colour_index)
	);

	// Result fields packed from the lowest bit up.
	assign m_tdata = {colour_index, envelope_level};

endmodule

/* src/rmsvu_checker.sv */
`include "rms_vu_level_envelope_top_macros.svh"

module rmsvu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A result that is not taken stays put.
	`RMSVU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Only one sample is in work at a time.
	`RMSVU_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "sample taken while busy")

	// A sample inside a buffer never produces a result.
	`RMSVU_ASSERT_NXT(a_no_spurious, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid, "result without a closing sample")

	// The colour index never exceeds the top byte of the envelope.
	`RMSVU_ASSERT_IMP(a_colour_bound, m_tvalid, m_tdata[23:16] <= m_tdata[15:8], "colour index out of range")

endmodule

bind rms_vu_level_envelope_top rmsvu_checker u_rmsvu_checker (.*);

/* dv/tb.sv */
// Stream-level testbench of the RMS level meter. Samples go in on the slave side, one
// transaction per sample, and the envelope comes back on the master side, one
// transaction per closed buffer. A behavioral copy of the meter in this module tracks
// the sum of squares, the count, the envelope and the three registers, and every
// result that the block returns is compared with the oldest outstanding prediction.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Behavioral constants of the meter: colour table size and longest counted buffer.
	localparam int COLOURS = 256;
	localparam int BUF_CAP = 4096;
	// Index three is not mapped to any register; writes to it must leave all state alone.
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed for a closing sample to work its way out of the block.
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS = 190;
	localparam int N_DIRECTED = 20;
	localparam int N_PHASES = 8;

	typedef struct packed {
		logic [15:0] envelope;
		logic [7:0]  colour;
	} level_result_t;

	// One directed sample; typed rows carry the result that the buffer must produce.
	typedef struct packed {
		logic [15:0] smp;
		logic        lst;
		logic        typed;
		logic [15:0] envelope;
		logic [7:0]  colour;
	} probe_row_t;

	typedef struct packed {
		logic [15:0] gain;
		logic [15:0] attack;
		logic [15:0] decay;
	} settings_t;

	// Loudness styles for the random buffers.
	typedef enum int {AMP_FULL, AMP_QUIET, AMP_SILENT, AMP_RAIL, AMP_SCALED} amp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	rms_vu_level_envelope_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the meter: registers and buffer state.
	logic [11:0] gain_reg;
	logic [15:0] attack_reg;
	logic [15:0] decay_reg;
	logic [42:0] sq_acc;
	logic [12:0] smp_cnt;
	logic [15:0] env_acc;

	// Envelopes still owed by the block, oldest first.
	level_result_t pending_levels[$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  rx_hold = 0;
	bit  rx_burst = 1'b0;
	bit  tx_burst = 1'b0;

	// Integer square root, built up one result bit at a time from the top.
	function automatic logic [15:0] root_of(input logic [31:0] v);
		logic [15:0] r;
		logic [15:0] trial;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = r | (16'd1 << b);
			if (32'(trial) * 32'(trial) <= v) r = trial;
		end
		return r;
	endfunction

	// Mirrors one register write; the gain register keeps only its low twelve bits.
	function automatic void store_reg(input logic [1:0] idx, input logic [15:0] val);
		case (idx)
			rmsvu_pkg::CFG_GAIN:         gain_reg = val[11:0];
			rmsvu_pkg::CFG_ATTACK_COEFF: attack_reg = val;
			rmsvu_pkg::CFG_DECAY_COEFF:  decay_reg = val;
			default: ;
		endcase
	endfunction

	// Advances the shadow meter by one sample. Returns 1 when the sample closes a buffer,
	// with the new envelope and colour index in res.
	function automatic bit meter_update(input logic [15:0] smp, input logic lst,
	                                    output level_result_t res);
		logic [42:0] mean;
		logic [15:0] rms;
		logic [27:0] scaled;
		logic [15:0] lvl;
		logic [15:0] alpha;
		longint      diff;
		longint      prod;
		longint      nxt;
		res = '0;
		// Samples beyond the buffer capacity are neither summed nor counted.
		if (smp_cnt < BUF_CAP) begin
			sq_acc += 43'(longint'($signed(smp)) * longint'($signed(smp)));
			smp_cnt++;
		end
		if (!lst) return 1'b0;
		mean = (smp_cnt == 0) ? '0 : sq_acc / 43'(smp_cnt);
		rms = root_of(mean[31:0]);
		scaled = (28'(rms) * 28'(gain_reg)) >> 7;
		lvl = (scaled > 28'hFFFF) ? 16'hFFFF : scaled[15:0];
		alpha = (lvl > env_acc) ? attack_reg : decay_reg;
		diff = longint'(lvl) - longint'(env_acc);
		prod = longint'(alpha) * diff;
		// The arithmetic shift rounds the step toward minus infinity.
		nxt = longint'(env_acc) + (prod >>> 16);
		if (nxt < 0) nxt = 0;
		else if (nxt > 65535) nxt = 65535;
		env_acc = 16'(nxt);
		sq_acc = '0;
		smp_cnt = '0;
		res.envelope = env_acc;
		res.colour = 8'((32'(env_acc) * (COLOURS - 1)) >> 16);
		return 1'b1;
	endfunction

	// Offers one sample on the slave side after a random gap and waits for its
	// transaction. A valid that stays high across back-to-back samples is never
	// dropped in between, so only one assignment per signal lands in a time step.
	task automatic send_sample(input logic [15:0] smp, input logic lst,
	                           input bit fixed_given, input level_result_t fixed_val);
		level_result_t pred;
		int gap;
		if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		if (meter_update(smp, lst, pred))
			pending_levels.push_back(fixed_given ? fixed_val : pred);
	endtask

	// Writes all three registers and then pokes the unmapped index with junk.
	task automatic apply_settings(input settings_t cfg);
		logic [1:0]  idx [4];
		logic [15:0] val [4];
		idx = '{rmsvu_pkg::CFG_GAIN, rmsvu_pkg::CFG_ATTACK_COEFF,
		        rmsvu_pkg::CFG_DECAY_COEFF, CFG_UNMAPPED};
		val = '{cfg.gain, cfg.attack, cfg.decay, 16'($urandom)};
		for (int k = 0; k < 4; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			store_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Lets every owed result come out, then gives a closing sample that produced no
	// result yet enough time to finish, so that a register write cannot race it.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] draw_sample(input amp_t style);
		logic [15:0] x;
		case (style)
			AMP_FULL:   x = 16'($urandom);
			AMP_QUIET:  x = 16'($urandom_range(0, 511) - 256);
			AMP_SILENT: x = '0;
			AMP_RAIL:   x = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: begin
				x = 16'($urandom);
				x = 16'($signed(x) >>> $urandom_range(1, 14));
			end
		endcase
		return x;
	endfunction

	// Random buffers: mostly short ones so that results are frequent, some medium,
	// a few long. Each buffer keeps one loudness style for all of its samples.
	task automatic run_buffers(input int n_items);
		int   sent;
		int   len;
		int   pick;
		amp_t style;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) len = $urandom_range(1, 12);
			else if (pick < 19) len = $urandom_range(13, 64);
			else len = $urandom_range(65, 300);
			pick = $urandom_range(0, 9);
			if (pick < 4) style = AMP_FULL;
			else if (pick < 6) style = AMP_SCALED;
			else if (pick < 8) style = AMP_QUIET;
			else if (pick < 9) style = AMP_RAIL;
			else style = AMP_SILENT;
			for (int i = 0; i < len; i++) begin
				send_sample(draw_sample(style), i == len - 1, 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Result side: checks each transaction against the oldest prediction and then
	// stalls for a random number of cycles, with runs of no stalling now and then.
	always @(posedge clk) begin
		level_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none outstanding: envelope %0d colour %0d",
					         $realtime, m_tdata[15:0], m_tdata[23:16]);
			end else begin
				want = pending_levels.pop_front();
				if (m_tdata[15:0] !== want.envelope || m_tdata[23:16] !== want.colour) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: envelope exp %0d got %0d, colour exp %0d got %0d",
						         $realtime, want.envelope, m_tdata[15:0],
						         want.colour, m_tdata[23:16]);
				end
			end
			if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			rx_hold = rx_burst ? 0 : $urandom_range(0, 15);
		end else if (rx_hold > 0) begin
			rx_hold--;
		end
		m_tready <= (rx_hold == 0);
	end

	// Watchdog: any transaction or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		probe_row_t probes [N_DIRECTED];
		settings_t  plan [N_PHASES];
		level_result_t typed_val;

		// Register values after reset and an empty meter.
		gain_reg = rmsvu_pkg::GAIN_RST;
		attack_reg = rmsvu_pkg::ATTACK_RST;
		decay_reg = rmsvu_pkg::DECAY_RST;
		sq_acc = '0;
		smp_cnt = '0;
		env_acc = '0;

		// Directed samples at reset settings (gain 6.0, attack 0.9, decay 0.05).
		probes = '{
			// Silence straight after reset leaves the envelope at zero.
			'{16'h0000, 1'b1, 1'b1, 16'd0, 8'd0},
			// A lone most-negative sample saturates the level; attack moves the
			// envelope to 0.9 of full scale.
			'{16'h8000, 1'b1, 1'b1, 16'd58981, 8'd229},
			'{16'h7FFF, 1'b1, 1'b0, 16'd0, 8'd0},
			// Silent buffer of four samples: the decay weight pulls the envelope down.
			'{16'h0000, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h0000, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h0000, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h0000, 1'b1, 1'b0, 16'd0, 8'd0},
			// Smallest nonzero magnitudes.
			'{16'h0001, 1'b1, 1'b0, 16'd0, 8'd0},
			'{16'hFFFF, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h0001, 1'b1, 1'b0, 16'd0, 8'd0},
			// Alternating rails.
			'{16'h7FFF, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h8000, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h7FFF, 1'b1, 1'b0, 16'd0, 8'd0},
			// Checkerboard and byte patterns toggle every sample bit.
			'{16'h00FF, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'hFF00, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'h5555, 1'b0, 1'b0, 16'd0, 8'd0},
			'{16'hAAAA, 1'b1, 1'b0, 16'd0, 8'd0},
			// Single-sample silent buffers while the envelope decays.
			'{16'h0000, 1'b1, 1'b0, 16'd0, 8'd0},
			'{16'h0000, 1'b1, 1'b0, 16'd0, 8'd0},
			'{16'h0000, 1'b1, 1'b0, 16'd0, 8'd0}
		};

		// Register settings per random phase: both extremes of every register, gain
		// data with junk in the upper nibble, the reset values, then random ones.
		plan[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
		plan[1] = '{16'h0000, 16'h0000, 16'h0000};
		plan[2] = '{16'hF001, 16'hFFFF, 16'h0000};
		plan[3] = '{16'h0100, 16'h0001, 16'hFFFF};
		plan[4] = '{16'h0300, 16'hE666, 16'h0CCD};
		for (int p = 5; p < N_PHASES; p++)
			plan[p] = '{16'($urandom), 16'($urandom), 16'($urandom)};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			typed_val.envelope = probes[r].envelope;
			typed_val.colour = probes[r].colour;
			send_sample(probes[r].smp, probes[r].lst, probes[r].typed, typed_val);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			apply_settings(plan[p]);
			run_buffers(PHASE_ITEMS);
		end

		s_tvalid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_levels.size() != 0)
			$display("%0d results never arrived", pending_levels.size());
		if (mismatches == 0 && pending_levels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
